[sv/sed_pkg.sv]
package sed_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF   = 32'h7F80_0000;

  typedef struct packed {
    logic [31:0] delta;
    logic        last;
  } item_t;

  // exact binary16 -> binary32 widening
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  mt;
    logic [31:0] res;
    logic [3:0]  pos;
    logic        found;
    logic [9:0]  sh;
    ex = h[14:10];
    mt = h[9:0];
    res = {h[15], 31'b0};
    pos = 4'd0;
    found = 1'b0;
    if (ex == 5'd31) begin
      res = {h[15], 8'hFF, mt, 13'b0};
    end else if (ex != 5'd0) begin
      res = {h[15], 3'b0, ex, mt, 13'b0} + {1'b0, 8'd112, 23'b0};
    end else if (mt != 10'd0) begin
      for (int i = 9; i >= 0; i--) begin
        if (!found && mt[i]) begin
          pos = 4'(i);
          found = 1'b1;
        end
      end
      // value = mt * 2^-24, leading one at bit pos
      sh = mt << (4'd10 - pos);
      res = {h[15], 8'(8'd103 + {4'b0, pos}), sh, 13'b0};
    end
    return res;
  endfunction

  function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [31:0] big, sml;
    logic [8:0]  e_big, e_sml;
    logic [23:0] m_big, m_sml;
    logic [7:0]  d;
    logic [53:0] wide;
    logic [26:0] ms;
    logic [27:0] sum;
    logic [4:0]  lz;
    logic        found;
    logic [8:0]  sh;
    logic [8:0]  e;
    logic [26:0] n;
    logic [31:0] res;
    logic        rnd;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:0] == POS_INF[30:0]);
    b_inf = (b[30:0] == POS_INF[30:0]);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    e_big = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
    e_sml = (sml[30:23] == 8'd0) ? 9'd1 : {1'b0, sml[30:23]};
    m_big = {big[30:23] != 8'd0, big[22:0]};
    m_sml = {sml[30:23] != 8'd0, sml[22:0]};
    d = 8'(e_big - e_sml);
    if (d >= 8'd27) begin
      ms = {26'b0, m_sml != 24'd0};
    end else begin
      wide = {m_sml, 3'b0, 27'b0} >> d;
      ms = wide[53:27];
      ms[0] = ms[0] | (wide[26:0] != 27'd0);
    end
    if (big[31] != sml[31]) sum = {1'b0, m_big, 3'b0} - {1'b0, ms};
    else                    sum = {1'b0, m_big, 3'b0} + {1'b0, ms};
    lz = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && sum[i]) begin
        lz = 5'(26 - i);
        found = 1'b1;
      end
    end
    if (sum[27]) begin
      n = sum[27:1];
      n[0] = n[0] | sum[0];
      e = e_big + 9'd1;
    end else begin
      sh = ({4'b0, lz} < (e_big - 9'd1)) ? {4'b0, lz} : (e_big - 9'd1);
      n = sum[26:0] << sh;
      e = e_big - sh;
    end
    rnd = n[2] & (n[1] | n[0] | n[3]);
    res = {big[31], (n[26] ? e[7:0] : 8'd0), n[25:3]} + {31'b0, rnd};
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      res = CANON_NAN;
    end else if (a_inf || b_inf) begin
      res = {big[31], POS_INF[30:0]};
    end else if (sum == 28'd0) begin
      res = {a[31] & b[31], 31'b0};
    end else if (e >= 9'd255) begin
      res = {big[31], POS_INF[30:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
    logic [8:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        p;
    logic [5:0]         lz;
    logic               found;
    logic signed [10:0] ee;
    logic [7:0]         rs;
    logic [95:0]        wide;
    logic               st;
    logic               rnd;
    logic [31:0]        res;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:0] == POS_INF[30:0]);
    b_inf  = (b[30:0] == POS_INF[30:0]);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    s  = a[31] ^ b[31];
    ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    lz = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && p[i]) begin
        lz = 6'(47 - i);
        found = 1'b1;
      end
    end
    p  = p << lz;
    ee = 11'($signed({2'b0, ea}) + $signed({2'b0, eb}) - 11'sd126 - $signed({5'b0, lz}));
    st = 1'b0;
    if (ee < 11'sd1) begin
      rs = 8'(11'sd1 - ee);
      if (rs >= 8'd49) begin
        st = (p != 48'd0);
        p = 48'd0;
      end else begin
        wide = {p, 48'b0} >> rs;
        p = wide[95:48];
        st = (wide[47:0] != 48'd0);
      end
      ee = 11'sd0;
    end
    st  = st | (p[22:0] != 23'd0);
    rnd = p[23] & (st | p[24]);
    res = {s, (p[47] ? ee[7:0] : 8'd0), p[46:24]} + {31'b0, rnd};
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      res = CANON_NAN;
    end else if (a_inf || b_inf) begin
      res = {s, POS_INF[30:0]};
    end else if (a_zero || b_zero) begin
      res = {s, 31'b0};
    end else if (ee >= 11'sd255) begin
      res = {s, POS_INF[30:0]};
    end
    return res;
  endfunction

endpackage

[sv/sed_fifo.sv]
module sed_fifo #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = sed_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({wr_en_i, rd_en_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[sv/sed_front.sv]
module sed_front (
  input  logic            push_i,
  input  logic            full_i,
  input  logic [15:0]     query_half_i,
  input  logic [15:0]     row_half_i,
  input  logic            last_element_i,
  output logic            wr_en_o,
  output sed_pkg::item_t  item_o
);

  logic [31:0] q_wide, r_wide;

  // widen both halves and form row - query
  assign q_wide        = sed_pkg::widen_half(query_half_i);
  assign r_wide        = sed_pkg::widen_half(row_half_i);
  assign item_o.delta  = sed_pkg::fp32_add(r_wide, {~q_wide[31], q_wide[30:0]});
  assign item_o.last   = last_element_i;
  assign wr_en_o       = push_i && !full_i;

endmodule

[sv/sed_back.sv]
module sed_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_empty_i,
  input  sed_pkg::item_t in_item_i,
  output logic           in_rd_o,
  input  logic           out_full_i,
  output logic           out_wr_o,
  output logic [31:0]    out_data_o
);

  logic        v1_q, v1_d;
  logic        last1_q;
  logic [31:0] prod_q;
  logic [31:0] sum_q, sum_d;
  logic [31:0] acc;
  logic        fire2, adv;

  assign fire2   = v1_q && (!last1_q || !out_full_i);
  assign adv     = !v1_q || fire2;
  assign in_rd_o = adv && !in_empty_i;
  assign v1_d    = adv ? !in_empty_i : v1_q;

  assign acc        = sed_pkg::fp32_add(sum_q, prod_q);
  assign out_wr_o   = fire2 && last1_q;
  // canonicalize any NaN on the way out
  assign out_data_o = ((acc[30:23] == 8'hFF) && (acc[22:0] != 23'd0)) ? sed_pkg::CANON_NAN : acc;

  always_comb begin
    sum_d = sum_q;
    if (fire2) begin
      sum_d = last1_q ? 32'd0 : acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      sum_q <= 32'd0;
    end else begin
      v1_q  <= v1_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rd_o) begin
      prod_q  <= sed_pkg::fp32_mul(in_item_i.delta, in_item_i.delta);
      last1_q <= in_item_i.last;
    end
  end

endmodule

[sv/fp16_squared_euclidean_distance_core.sv]
// channel  | handshake   | payload
// input    | push / full | query_half_i, row_half_i, last_element_i
// result   | empty / pop | distance_bits_o
// One element per cycle unless a last element waits on a full result queue; the accumulator
// add closes a loop through one register. A result shows on empty low once its last element
// has passed the multiply register and been written to the result queue. Reset clears both
// queues, the multiply stage and the sum to +0. Pop low fills the result queue, then the
// multiply stage holds at the next last element and the element queue fills until full rises.
module fp16_squared_euclidean_distance_core #(
  parameter int unsigned FifoDepth = sed_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] query_half_i,
  input  logic [15:0] row_half_i,
  input  logic        last_element_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] distance_bits_o
);

  localparam int unsigned ItemW = $bits(sed_pkg::item_t);

  logic           in_wr, in_rd, in_empty;
  sed_pkg::item_t wr_item, rd_item;
  logic           out_wr, out_full;
  logic [31:0]    out_data;

  sed_front u_front (
    .push_i         (push),
    .full_i         (full),
    .query_half_i   (query_half_i),
    .row_half_i     (row_half_i),
    .last_element_i (last_element_i),
    .wr_en_o        (in_wr),
    .item_o         (wr_item)
  );

  sed_fifo #(.Width(ItemW), .Depth(FifoDepth)) u_in_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_wr),
    .wr_data_i (wr_item),
    .rd_en_i   (in_rd),
    .rd_data_o (rd_item),
    .full_o    (full),
    .empty_o   (in_empty)
  );

  sed_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_empty_i (in_empty),
    .in_item_i  (rd_item),
    .in_rd_o    (in_rd),
    .out_full_i (out_full),
    .out_wr_o   (out_wr),
    .out_data_o (out_data)
  );

  sed_fifo #(.Width(32), .Depth(FifoDepth)) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (out_wr),
    .wr_data_i (out_data),
    .rd_en_i   (pop && !empty),
    .rd_data_o (distance_bits_o),
    .full_o    (out_full),
    .empty_o   (empty)
  );

`ifndef NO_ASSERTIONS
  a_no_out_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wr |-> !out_full) else $error("result written to full queue");

  a_no_in_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_rd |-> !in_empty) else $error("element read from empty queue");

  a_canon_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && distance_bits_o[30:23] == 8'hFF && distance_bits_o[22:0] != 23'd0)
      |-> distance_bits_o == sed_pkg::CANON_NAN) else $error("non-canonical NaN result");
`endif

endmodule
